// ----- hdl/mhpq_pkg.sv -----
package mhpq_pkg;

  localparam int HEAP_DEPTH_DEF    = 1024;
  localparam int PID_BITS_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 16;

  localparam int FIELD_W  = 16;
  localparam int TOTAL_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ----- hdl/min_heap_priority_queue.sv -----
// Channel   Handshake        Payload
// command   start, busy      opcode, entry_pid, entry_priority
// result    done             top_pid, top_priority, top_valid, entry_total, status
//
// A command transfer happens at a clock edge with start high and busy low.
// An insert sifts the new entry up from the end of the heap; a remove takes the last entry
// to the root and sifts it down. The entry moves by at most log2(HEAP_DEPTH) heap levels.
// Each level takes a heap memory read state and a compare-and-write-back state.
// A refused command, an insert into an empty heap or a remove that empties it go to S_REPORT.
// Reset clears the entry count and the controller; the heap memory is not cleared.
// done is high for one cycle with each result and cannot be stalled; the results hold until the next report.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int HEAP_DEPTH    = HEAP_DEPTH_DEF,
  parameter int PID_BITS      = PID_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [FIELD_W-1:0] entry_pid,
  input  logic [FIELD_W-1:0] entry_priority,
  output logic               done,
  output logic [FIELD_W-1:0] top_pid,
  output logic [FIELD_W-1:0] top_priority,
  output logic               top_valid,
  output logic [TOTAL_W-1:0] entry_total,
  output logic [STATUS_W-1:0] status
);

  localparam int IW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = IW + 2;
  localparam int EW = PID_BITS + PRIORITY_BITS;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UP_RD   = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_DN_LAST = 7'b0001000,
    S_DN_RD   = 7'b0010000,
    S_DN_CMP  = 7'b0100000,
    S_REPORT  = 7'b1000000
  } state_t;

  state_t         state, state_next;
  logic [IW-1:0]  pos, pos_next;
  logic [CW-1:0]  count, count_next;
  logic [EW-1:0]  cur, cur_next;
  logic [EW-1:0]  root;
  status_t        st, st_next;

  logic           we;
  logic [IW-1:0]  waddr;
  logic [EW-1:0]  wdata;
  logic [IW-1:0]  raddr_a, raddr_b;
  logic [EW-1:0]  rdata_a, rdata_b;

  logic [EW-1:0]  in_entry;
  logic [IW-1:0]  parent;
  logic [XW-1:0]  lc_x, rc_x, count_x;
  logic           l_lt_r, l_lt_c, r_lt_c, up_lt;

  mhpq_mem #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign busy     = (state != S_IDLE);
  assign in_entry = {PID_BITS'(entry_pid), PRIORITY_BITS'(entry_priority)};
  assign parent   = IW'((pos - IW'(1)) >> 1);
  assign lc_x     = {1'b0, pos, 1'b1};
  assign rc_x     = lc_x + XW'(1);
  assign count_x  = XW'(count);
  assign up_lt    = cur[PRIORITY_BITS-1:0] < rdata_a[PRIORITY_BITS-1:0];
  assign l_lt_r   = rdata_a[PRIORITY_BITS-1:0] < rdata_b[PRIORITY_BITS-1:0];
  assign l_lt_c   = rdata_a[PRIORITY_BITS-1:0] < cur[PRIORITY_BITS-1:0];
  assign r_lt_c   = rdata_b[PRIORITY_BITS-1:0] < cur[PRIORITY_BITS-1:0];

  always_comb begin
    state_next = state;
    pos_next   = pos;
    count_next = count;
    cur_next   = cur;
    st_next    = st;
    we         = 1'b0;
    waddr      = pos;
    wdata      = cur;
    raddr_a    = IW'(lc_x);
    raddr_b    = IW'(rc_x);
    case (state)
      S_IDLE: begin
        raddr_a = IW'(count - CW'(1));
        if (start) begin
          st_next = ST_DONE;
          if (opcode == OP_INSERT) begin
            if (count == CW'(HEAP_DEPTH)) begin
              st_next    = ST_FULL;
              state_next = S_REPORT;
            end else begin
              cur_next   = in_entry;
              pos_next   = IW'(count);
              count_next = count + CW'(1);
              if (count == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = in_entry;
                state_next = S_REPORT;
              end else begin
                state_next = S_UP_RD;
              end
            end
          end else begin
            if (count == '0) begin
              st_next    = ST_EMPTY;
              state_next = S_REPORT;
            end else begin
              count_next = count - CW'(1);
              pos_next   = '0;
              state_next = (count == CW'(1)) ? S_REPORT : S_DN_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        raddr_a = parent;
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_REPORT;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_lt) begin
          wdata      = rdata_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_DN_LAST: begin
        cur_next   = rdata_a;
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        if (lc_x >= count_x) begin
          we         = 1'b1;
          state_next = S_REPORT;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if ((rc_x < count_x) && l_lt_r && l_lt_c) begin
          wdata      = rdata_a;
          pos_next   = IW'(lc_x);
          state_next = S_DN_RD;
        end else if ((rc_x < count_x) && r_lt_c) begin
          wdata      = rdata_b;
          pos_next   = IW'(rc_x);
          state_next = S_DN_RD;
        end else if ((rc_x >= count_x) && l_lt_c) begin
          wdata      = rdata_a;
          pos_next   = IW'(lc_x);
          state_next = S_DN_RD;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == S_REPORT);
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    cur <= cur_next;
    st  <= st_next;
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
    if (state == S_REPORT) begin
      top_valid   <= (count != '0);
      top_pid     <= (count != '0) ? FIELD_W'(root[EW-1:PRIORITY_BITS]) : '0;
      top_priority <= (count != '0) ? FIELD_W'(root[PRIORITY_BITS-1:0]) : '0;
      entry_total <= TOTAL_W'(count);
      status      <= st;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_DEPTH))
    else $error("entry count exceeds heap depth");

  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_REPORT))
    else $error("done without a report cycle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not make the block busy");

  a_sift_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN_RD) |-> (XW'(pos) < count_x))
    else $error("sift-down position outside the heap");

  a_valid_matches_total: assert property (@(posedge clk) disable iff (rst)
    done |-> (top_valid == (entry_total != '0)))
    else $error("top_valid disagrees with entry_total");
`endif

endmodule

// ----- hdl/mhpq_mem.sv -----
module mhpq_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
